// ----- hdl/rtp_pkg.sv -----
package rtp_pkg;

  // Default widths of the levels and of the time base.
  localparam int RTP_FRAC_BITS = 24;
  localparam int RTP_TIME_BITS = 32;

  // Fixed port widths.
  localparam int RTP_NOW_W      = 32;
  localparam int RTP_MS_W       = 31;
  localparam int RTP_CFG_IDX_W  = 3;
  localparam int RTP_CFG_DATA_W = 32;

  // The 0.20 threshold is 13421773 / 2^26, compared without rounding.
  localparam logic [23:0] RTP_TH_NUM   = 24'd13421773;
  localparam int          RTP_TH_SHIFT = 26;

  // Mode codes as they appear on the result word.
  typedef enum logic [2:0] {
    ST_OFF    = 3'd0,
    ST_IDLE   = 3'd1,
    ST_SPOOL  = 3'd2,
    ST_ACTIVE = 3'd3,
    ST_LOST   = 3'd4,
    ST_AUTO   = 3'd5,
    ST_BAIL   = 3'd6,
    ST_RECOV  = 3'd7
  } rtp_state_e;

  // Configuration register indexes.
  typedef enum logic [RTP_CFG_IDX_W-1:0] {
    CFG_SPOOLUP_STEP  = 3'd0,
    CFG_BAILOUT_STEP  = 3'd1,
    CFG_RECOVERY_STEP = 3'd2,
    CFG_AUTO_ENABLE   = 3'd3,
    CFG_AUTO_MIN_MS   = 3'd4,
    CFG_AUTO_TO_MS    = 3'd5,
    CFG_LOST_TO_MS    = 3'd6
  } rtp_cfg_idx_e;

  // Timing related configuration handed to the transition logic.
  typedef struct packed {
    logic                auto_en;
    logic [RTP_MS_W-1:0] auto_min_ms;
    logic [RTP_MS_W-1:0] auto_to_ms;
    logic [RTP_MS_W-1:0] lost_to_ms;
  } rtp_timer_cfg_t;

endpackage

// ----- hdl/rtp_ifs.sv -----
// Input item channel: one control step.
interface rtp_in_if import rtp_pkg::*; #(
  parameter int FRAC_BITS = RTP_FRAC_BITS
);
  logic                 valid;
  logic                 ready;
  logic                 armed;
  logic                 stick_low;
  logic [FRAC_BITS:0]   throttle;
  logic [RTP_NOW_W-1:0] now_ms;

  modport source (output valid, output armed, output stick_low, output throttle,
                  output now_ms, input ready);
  modport sink (input valid, input armed, input stick_low, input throttle,
                input now_ms, output ready);
endinterface

// Result channel: motor level and mode after the step.
interface rtp_out_if import rtp_pkg::*; #(
  parameter int FRAC_BITS = RTP_FRAC_BITS
);
  logic               valid;
  logic               ready;
  logic [FRAC_BITS:0] motor_out;
  logic [2:0]         mode_state;

  modport source (output valid, output motor_out, output mode_state, input ready);
  modport sink (input valid, input motor_out, input mode_state, output ready);
endinterface

// Configuration write channel.
interface rtp_cfg_if import rtp_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [RTP_CFG_IDX_W-1:0]  index;
  logic [RTP_CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hdl/rtp_core.sv -----
// Transition and output logic for one control step.
module rtp_core import rtp_pkg::*; #(
  parameter int FRAC_BITS = RTP_FRAC_BITS,
  parameter int TIME_BITS = RTP_TIME_BITS
) (
  input  rtp_state_e           state_i,
  input  logic [FRAC_BITS:0]   last_i,
  input  logic [TIME_BITS-1:0] entry_i,
  input  logic                 armed_i,
  input  logic                 stick_low_i,
  input  logic [FRAC_BITS:0]   throttle_i,
  input  logic [TIME_BITS-1:0] now_i,
  input  logic [FRAC_BITS:0]   spoolup_step_i,
  input  logic [FRAC_BITS:0]   bailout_step_i,
  input  logic [FRAC_BITS:0]   recovery_step_i,
  input  rtp_timer_cfg_t       tcfg_i,
  output rtp_state_e           next_o,
  output logic [FRAC_BITS:0]   motor_o,
  output logic                 entry_upd_o
);

  localparam int SH_W = FRAC_BITS + 1 + RTP_TH_SHIFT;
  localparam logic [SH_W-1:0] TH_SH = SH_W'(RTP_TH_NUM) << FRAC_BITS;

  logic [SH_W-1:0]      thr_sh;
  logic                 above_th;
  logic                 below_th;
  logic [FRAC_BITS:0]   step;
  logic [FRAC_BITS+1:0] sum;
  logic [FRAC_BITS:0]   rise;
  logic [TIME_BITS-1:0] delta;
  logic [31:0]          delta_pos;
  logic                 auto_min_over;
  logic                 auto_to_over;
  logic                 lost_to_over;

  // Exact compare against the 0.20 threshold.
  assign thr_sh   = {throttle_i, {RTP_TH_SHIFT{1'b0}}};
  assign above_th = thr_sh > TH_SH;
  assign below_th = thr_sh < TH_SH;

  // Rise limit: pick the step of the current state, then one add and a min.
  always_comb begin
    case (state_i)
      ST_AUTO, ST_BAIL: step = bailout_step_i;
      ST_RECOV:         step = recovery_step_i;
      default:          step = spoolup_step_i;
    endcase
  end

  assign sum = {1'b0, last_i} + {1'b0, step};

  always_comb begin
    if (throttle_i > last_i) begin
      rise = (sum < {1'b0, throttle_i}) ? sum[FRAC_BITS:0] : throttle_i;
    end else begin
      rise = throttle_i;
    end
  end

  // Elapsed time since state entry; a negative difference never times out.
  assign delta     = now_i - entry_i;
  assign delta_pos = 32'(delta[TIME_BITS-2:0]);
  assign auto_min_over = !delta[TIME_BITS-1] && (delta_pos > 32'(tcfg_i.auto_min_ms));
  assign auto_to_over  = !delta[TIME_BITS-1] && (delta_pos > 32'(tcfg_i.auto_to_ms));
  assign lost_to_over  = !delta[TIME_BITS-1] && (delta_pos > 32'(tcfg_i.lost_to_ms));

  // Next mode and motor level.
  always_comb begin
    next_o  = state_i;
    motor_o = '0;
    if (!armed_i) begin
      next_o = ST_OFF;
    end else begin
      case (state_i)
        ST_OFF: begin
          if (!stick_low_i) next_o = ST_IDLE;
        end
        ST_IDLE: begin
          motor_o = rise;
          if (stick_low_i) next_o = ST_OFF;
          else if (above_th) next_o = ST_SPOOL;
        end
        ST_SPOOL: begin
          motor_o = rise;
          if (stick_low_i) next_o = ST_OFF;
          else if (below_th) next_o = ST_IDLE;
          else if (rise >= throttle_i) next_o = ST_ACTIVE;
        end
        ST_ACTIVE: begin
          motor_o = throttle_i;
          if (stick_low_i) next_o = ST_LOST;
          else if (below_th) begin
            if (tcfg_i.auto_en && auto_min_over) next_o = ST_AUTO;
            else next_o = ST_IDLE;
          end
        end
        ST_LOST: begin
          if (!stick_low_i) next_o = ST_RECOV;
          else if (lost_to_over) next_o = ST_OFF;
        end
        ST_AUTO: begin
          motor_o = rise;
          if (stick_low_i) next_o = ST_LOST;
          else if (above_th) next_o = ST_BAIL;
          else if (auto_to_over) next_o = ST_IDLE;
        end
        ST_BAIL: begin
          motor_o = rise;
          if (stick_low_i) next_o = ST_LOST;
          else if (below_th) next_o = ST_AUTO;
          else if (rise >= throttle_i) next_o = ST_ACTIVE;
        end
        default: begin
          motor_o = rise;
          if (stick_low_i) next_o = ST_LOST;
          else if (below_th) next_o = ST_IDLE;
          else if (rise >= throttle_i) next_o = ST_ACTIVE;
        end
      endcase
    end
  end

  // Disarm and every mode change restart the entry time.
  assign entry_upd_o = !armed_i || (next_o != state_i);

endmodule

// ----- hdl/rotor_throttle_passthrough_fsm.sv -----
// Channel   Direction  Handshake      Word
// in_i      sink       valid/ready    armed, stick_low, throttle, now_ms
// out_o     source     valid/ready    motor_out, mode_state
// cfg_i     sink       valid/ready    index, data (ready is always high)
//
// One word per cycle sustained while out_o is ready; every input word gives one
// result word, registered in the input register, then in the result register.
// The mode, last output and entry time update when a word leaves the input register.
// Reset clears all configuration registers, the mode (off), last output and entry time.
// A stalled result register holds its word while one more input word is taken.
module rotor_throttle_passthrough_fsm import rtp_pkg::*; #(
  parameter int FRAC_BITS = RTP_FRAC_BITS,
  parameter int TIME_BITS = RTP_TIME_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rtp_in_if.sink    in_i,
  rtp_out_if.source out_o,
  rtp_cfg_if.sink   cfg_i
);

  // Configuration registers.
  logic [FRAC_BITS:0] spoolup_q;
  logic [FRAC_BITS:0] bailout_q;
  logic [FRAC_BITS:0] recovery_q;
  rtp_timer_cfg_t     tcfg_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spoolup_q  <= '0;
      bailout_q  <= '0;
      recovery_q <= '0;
      tcfg_q     <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_SPOOLUP_STEP:  spoolup_q          <= cfg_i.data[FRAC_BITS:0];
        CFG_BAILOUT_STEP:  bailout_q          <= cfg_i.data[FRAC_BITS:0];
        CFG_RECOVERY_STEP: recovery_q         <= cfg_i.data[FRAC_BITS:0];
        CFG_AUTO_ENABLE:   tcfg_q.auto_en     <= cfg_i.data[0];
        CFG_AUTO_MIN_MS:   tcfg_q.auto_min_ms <= cfg_i.data[RTP_MS_W-1:0];
        CFG_AUTO_TO_MS:    tcfg_q.auto_to_ms  <= cfg_i.data[RTP_MS_W-1:0];
        CFG_LOST_TO_MS:    tcfg_q.lost_to_ms  <= cfg_i.data[RTP_MS_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake.
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_free, s1_fire, in_fire;

  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign in_fire    = in_i.valid && in_i.ready;

  assign s1_valid_d  = in_fire || (s1_valid_q && !s1_fire);
  assign out_valid_d = s1_fire || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input register.
  logic                 s1_armed_q;
  logic                 s1_low_q;
  logic [FRAC_BITS:0]   s1_throttle_q;
  logic [TIME_BITS-1:0] s1_now_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_armed_q    <= in_i.armed;
      s1_low_q      <= in_i.stick_low;
      s1_throttle_q <= in_i.throttle;
      s1_now_q      <= in_i.now_ms[TIME_BITS-1:0];
    end
  end

  // Mode machine state.
  rtp_state_e           state_q, state_d;
  logic [FRAC_BITS:0]   last_q, motor_d;
  logic [TIME_BITS-1:0] entry_q;
  logic                 entry_upd;

  rtp_core #(
    .FRAC_BITS(FRAC_BITS),
    .TIME_BITS(TIME_BITS)
  ) u_core (
    .state_i        (state_q),
    .last_i         (last_q),
    .entry_i        (entry_q),
    .armed_i        (s1_armed_q),
    .stick_low_i    (s1_low_q),
    .throttle_i     (s1_throttle_q),
    .now_i          (s1_now_q),
    .spoolup_step_i (spoolup_q),
    .bailout_step_i (bailout_q),
    .recovery_step_i(recovery_q),
    .tcfg_i         (tcfg_q),
    .next_o         (state_d),
    .motor_o        (motor_d),
    .entry_upd_o    (entry_upd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_OFF;
      last_q  <= '0;
      entry_q <= '0;
    end else if (s1_fire) begin
      state_q <= state_d;
      last_q  <= motor_d;
      if (entry_upd) entry_q <= s1_now_q;
    end
  end

  // Result register.
  logic [FRAC_BITS:0] out_motor_q;
  rtp_state_e         out_mode_q;

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_motor_q <= motor_d;
      out_mode_q  <= state_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.motor_out  = out_motor_q;
  assign out_o.mode_state = out_mode_q;

  // A disarmed step always reports off with the motor stopped.
  a_disarm_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && !s1_armed_q |=> out_valid_q && out_motor_q == '0 && out_mode_q == ST_OFF)
    else $error("disarmed step did not report off with zero output");

  // The motor level never exceeds the commanded throttle.
  a_motor_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_motor_q <= $past(s1_throttle_q))
    else $error("motor output above throttle");

  // The reported mode is the mode the machine moved to.
  a_mode_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_mode_q == state_q && out_motor_q == last_q)
    else $error("result word disagrees with machine state");

endmodule
